FILE: hw/rtl/pes_pkg.sv
// package for the periodic event scheduler core
// types, opcodes, status codes and sizes; no dependencies
package pes_pkg;
  localparam int unsigned MaxSources = 64;
  localparam int unsigned IdxW = $clog2(MaxSources);
  localparam int unsigned CntW = $clog2(MaxSources + 1);

  typedef enum logic [1:0] {
    OpRegister = 2'd0,
    OpServe    = 2'd1,
    OpClear    = 2'd2,
    OpNone     = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    StServed = 2'd0,
    StEmpty  = 2'd1,
    StFull   = 2'd2,
    StNone   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SIdle, SScan, SLast, SWrite, SOut
  } state_e;

  typedef struct packed {
    logic [31:0] due;
    logic [31:0] id;
    logic [15:0] period;
  } entry_t;
endpackage

FILE: hw/rtl/pes_table.sv
// entry table memory for the scheduler: one write port, one registered read port
// depends on pes_pkg
module pes_table import pes_pkg::*; (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  entry_t          wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output entry_t          rdata_o
);
  entry_t mem [MaxSources];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: hw/rtl/periodic_event_scheduler_core.sv
// periodic event scheduler: table of sources, serves the earliest due entry
// register and clear are handled in the idle state; register emits a full status item when the table is full
// serve emits an empty status item on an empty table; else it scans, writes back the entry and emits the item
// one item at a time; the linear scan over the memory read port sets the serve time
// results leave through an output register; a new item waits until it is taken
// reset (async, active low) empties the table; entry contents stay undefined
module periodic_event_scheduler_core import pes_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [55:0] s_tdata_i,  // source_id[31:0], period[47:32], zero fill
  input  logic [1:0]  s_tuser_i,  // opcode[1:0]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [31:0] m_tdata_o,  // served_id[31:0]
  output logic [1:0]  m_tuser_o   // status[1:0]
);
  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] raddr_q, raddr_d;   // address whose data arrives now; raddr_d is the next address to read
  logic [IdxW-1:0] cur_q, cur_d;       // address whose data arrives now
  logic [IdxW-1:0] best_q, best_d;
  entry_t best_e_q, best_e_d;
  logic out_v_q, out_v_d;
  logic [31:0] out_id_q, out_id_d;
  logic [1:0] out_st_q, out_st_d;
  logic we;
  logic [IdxW-1:0] waddr;
  entry_t wdata, rdata;
  logic acc;
  logic [32:0] sum;
  logic better;

  pes_table u_table (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr_d), .rdata_o(rdata)
  );

  assign s_tready_o = (state_q == SIdle) && !out_v_q;
  assign acc = s_tvalid_i && s_tready_o;
  assign m_tvalid_o = out_v_q;
  assign m_tdata_o = out_id_q;
  assign m_tuser_o = out_st_q;

  // candidate beats current best on due time, then smaller id
  assign better = (rdata.due < best_e_q.due) ||
                  ((rdata.due == best_e_q.due) && (rdata.id < best_e_q.id));
  assign sum = {1'b0, best_e_q.due} + {17'd0, best_e_q.period};

  always_comb begin
    state_d = state_q; count_d = count_q; raddr_d = raddr_q; cur_d = cur_q;
    best_d = best_q; best_e_d = best_e_q;
    out_v_d = out_v_q; out_id_d = out_id_q; out_st_d = out_st_q;
    we = 1'b0; waddr = count_q[IdxW-1:0];
    wdata = '{due: {16'd0, s_tdata_i[47:32]}, id: s_tdata_i[31:0],
              period: s_tdata_i[47:32]};
    if (out_v_q && m_tready_i) out_v_d = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (acc) begin
          unique case (opcode_e'(s_tuser_i))
            OpRegister: begin
              if (count_q >= CntW'(MaxSources)) begin
                out_v_d = 1'b1; out_id_d = '0; out_st_d = StFull;
              end else begin
                we = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            OpServe: begin
              if (count_q == '0) begin
                out_v_d = 1'b1; out_id_d = '0; out_st_d = StEmpty;
              end else begin
                raddr_d = '0; cur_d = '0; best_d = '0;
                state_d = SScan;
              end
            end
            OpClear: count_d = '0;
            default: ;
          endcase
        end
      end
      SScan: begin
        // entry 0 data arrives: seed best, start reading entry 1
        best_e_d = rdata; best_d = '0;
        raddr_d = IdxW'(1); cur_d = IdxW'(1);
        state_d = (count_q == CntW'(1)) ? SWrite : SLast;
      end
      SLast: begin
        if (better) begin best_e_d = rdata; best_d = cur_q; end
        if ({1'b0, cur_q} == CntW'(count_q - 1'b1)) state_d = SWrite;
        else begin
          raddr_d = cur_q + 1'b1; cur_d = cur_q + 1'b1;
        end
      end
      SWrite: begin
        we = 1'b1; waddr = best_q;
        wdata = best_e_q;
        wdata.due = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        state_d = SOut;
      end
      SOut: begin
        if (!out_v_q) begin
          out_v_d = 1'b1; out_id_d = best_e_q.id; out_st_d = StServed;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; count_q <= '0; out_v_q <= 1'b0;
    end else begin
      state_q <= state_d; count_q <= count_d; out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q <= raddr_d; cur_q <= cur_d; best_q <= best_d; best_e_q <= best_e_d;
    out_id_q <= out_id_d; out_st_q <= out_st_d;
  end
endmodule
